@@ hdl/spnh_pkg.sv @@
// ----------------------------------------------------------------------------
// spnh_pkg
// Shared widths, function codes and register indexes of the next-hop router.
// ----------------------------------------------------------------------------
package spnh_pkg;

  localparam int NODE_W        = 6;
  localparam int COUNT_W       = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int DEF_MAX_NODES = 64;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(64);

  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    FN_SET_LINK   = 2'd0,
    FN_WRITE_EDGE = 2'd1,
    FN_CLEAR_ROW  = 2'd2,
    FN_QUERY      = 2'd3
  } func_t;

  localparam cfg_idx_t REG_SELF_ID    = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_NODE_COUNT = CFG_IDX_W'(1);

endpackage

@@ hdl/spnh_if.sv @@
// ----------------------------------------------------------------------------
// spnh_if
// Valid/ready channels of the next-hop router: requests, responses, config.
// ----------------------------------------------------------------------------
interface spnh_req_if;
  logic                  valid;
  logic                  ready;
  spnh_pkg::func_t       func;
  spnh_pkg::node_t       node_a;
  spnh_pkg::node_t       node_b;
  logic                  present;

  modport source (output valid, output func, output node_a, output node_b,
                  output present, input ready);
  modport sink   (input valid, input func, input node_a, input node_b,
                  input present, output ready);
endinterface

interface spnh_rsp_if;
  logic                  valid;
  logic                  ready;
  spnh_pkg::node_t       next_hop;
  logic                  has_route;

  modport source (output valid, output next_hop, output has_route, input ready);
  modport sink   (input valid, input next_hop, input has_route, output ready);
endinterface

interface spnh_cfg_if;
  logic                  valid;
  logic                  ready;
  spnh_pkg::cfg_idx_t    index;
  spnh_pkg::cfg_data_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/spnh_ram.sv @@
// ----------------------------------------------------------------------------
// spnh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/spnh_relax.sv @@
// ----------------------------------------------------------------------------
// spnh_relax
// Edge test: decides whether node v joins the next level through u,
// and which first hop it inherits.
// ----------------------------------------------------------------------------
module spnh_relax #(
  parameter int MAX_NODES = spnh_pkg::DEF_MAX_NODES
) (
  input  logic [$clog2(MAX_NODES)-1:0] u,
  input  logic [$clog2(MAX_NODES)-1:0] v,
  input  logic [$clog2(MAX_NODES)-1:0] self_idx,
  input  logic [MAX_NODES-1:0]         own_up,
  input  logic [MAX_NODES-1:0]         row_u,
  input  logic [MAX_NODES-1:0]         row_v,
  input  logic                         row_v_ok,
  input  logic                         visited_v,
  input  logic [$clog2(MAX_NODES)-1:0] hop_u,
  output logic                         take,
  output logic [$clog2(MAX_NODES)-1:0] hop
);

  logic u_is_self;
  logic v_is_self;
  logic adj;

  always_comb begin
    u_is_self = (u == self_idx);
    v_is_self = (v == self_idx);
    // links touching this node count only through the own-link bits
    if (u == v) begin
      adj = 1'b0;
    end else if (u_is_self) begin
      adj = own_up[v];
    end else if (v_is_self) begin
      adj = own_up[u];
    end else begin
      adj = row_u[v] | (row_v_ok & row_v[u]);
    end
    take = adj & ~visited_v;
    hop  = u_is_self ? v : hop_u;
  end

endmodule

@@ hdl/shortest_path_next_hop_top.sv @@
// ----------------------------------------------------------------------------
// shortest_path_next_hop_top
// Topology store and unit-weight shortest-path next-hop lookup.
// ----------------------------------------------------------------------------
// An edge write reads the old row, then writes it back with the new bit; a
// query on clean routes reads the route table and then answers. A query after
// any change first rebuilds the routes level by level, scanning rows through
// the edge memory's single read port (one row a cycle).
// One request at a time; ready is low while busy.
// Reset clears all links, edges (per-row valid bits) and routes; no sweep.
module shortest_path_next_hop_top #(
  parameter int MAX_NODES = spnh_pkg::DEF_MAX_NODES
) (
  input  logic            clk,
  input  logic            rst,
  spnh_req_if.sink        req,
  spnh_rsp_if.source      rsp,
  spnh_cfg_if.sink        cfg
);
  import spnh_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_WR,
    S_RC_INIT,
    S_RC_SCANU,
    S_RC_LOADU,
    S_RC_SCANV,
    S_Q_RD,
    S_Q_ANS
  } state_t;

  state_t               state;
  node_t                self_id;
  count_t               node_count;
  logic [MAX_NODES-1:0] own_up;
  logic [MAX_NODES-1:0] row_ok;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] front;
  logic [MAX_NODES-1:0] nxt;
  logic                 stale;
  logic [CW-1:0]        u;
  logic [CW-1:0]        v;
  logic                 p_valid;
  logic [IW-1:0]        p_v;
  logic [MAX_NODES-1:0] row_u;
  logic [IW-1:0]        hop_u;
  node_t                req_a;
  node_t                req_b;
  logic                 req_present;
  logic                 out_valid;
  node_t                out_hop;
  logic                 out_ok;

  logic                 e_we;
  logic [IW-1:0]        e_waddr;
  logic [MAX_NODES-1:0] e_wdata;
  logic                 e_re;
  logic [IW-1:0]        e_raddr;
  logic [MAX_NODES-1:0] e_rdata;
  logic                 h_we;
  logic [IW-1:0]        h_waddr;
  logic [IW-1:0]        h_wdata;
  logic                 h_re;
  logic [IW-1:0]        h_raddr;
  logic [IW-1:0]        h_rdata;

  logic [CW-1:0]        n_eff;
  logic [IW-1:0]        self_idx;
  logic                 self_in;
  logic [IW-1:0]        u_idx;
  logic [IW-1:0]        in_idx;
  logic                 a_ok;
  logic                 b_ok;
  logic                 req_fire;
  logic                 u_load;
  logic                 take;
  logic [IW-1:0]        relax_hop;
  logic                 q_valid;
  logic                 q_ok;
  node_t                q_hop;

  assign n_eff    = (32'(node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count);
  assign self_idx = IW'(self_id);
  assign self_in  = 32'(self_id) < 32'(n_eff);
  assign u_idx    = u[IW-1:0];
  assign in_idx   = IW'(req.node_a);
  assign a_ok     = 32'(req.node_a) < MAX_NODES;
  assign b_ok     = 32'(req.node_b) < MAX_NODES;

  assign req.ready     = (state == S_IDLE);
  assign req_fire      = req.valid && req.ready;
  assign cfg.ready     = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.next_hop  = out_hop;
  assign rsp.has_route = out_ok;

  assign u_load = (state == S_RC_SCANU) && (u != n_eff) && front[u_idx];

  // memory port control
  always_comb begin
    e_re    = 1'b0;
    e_raddr = u_idx;
    if (req_fire && (req.func == FN_WRITE_EDGE) && a_ok && b_ok) begin
      e_re    = 1'b1;
      e_raddr = in_idx;
    end else if (u_load) begin
      e_re    = 1'b1;
      e_raddr = u_idx;
    end else if ((state == S_RC_SCANV) && (v != n_eff)) begin
      e_re    = 1'b1;
      e_raddr = v[IW-1:0];
    end

    e_we    = (state == S_EDGE_WR);
    e_waddr = IW'(req_a);
    e_wdata = row_ok[IW'(req_a)] ? e_rdata : '0;
    e_wdata[IW'(req_b)] = req_present;

    h_re    = u_load || (state == S_Q_RD);
    h_raddr = (state == S_Q_RD) ? IW'(req_a) : u_idx;
    h_we    = (state == S_RC_SCANV) && p_valid && take;
    h_waddr = p_v;
    h_wdata = relax_hop;
  end

  // answer from the finished route table
  always_comb begin
    q_valid = (32'(req_a) < 32'(n_eff)) && visited[IW'(req_a)] && (req_a != self_id);
    q_ok    = q_valid && own_up[h_rdata];
    q_hop   = q_ok ? NODE_W'(h_rdata) : '0;
  end

  spnh_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  spnh_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_NODES)
  ) u_hop_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  spnh_relax #(
    .MAX_NODES (MAX_NODES)
  ) u_relax (
    .u         (u_idx),
    .v         (p_v),
    .self_idx  (self_idx),
    .own_up    (own_up),
    .row_u     (row_u),
    .row_v     (e_rdata),
    .row_v_ok  (row_ok[p_v]),
    .visited_v (visited[p_v]),
    .hop_u     (hop_u),
    .take      (take),
    .hop       (relax_hop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      self_id    <= '0;
      node_count <= NODE_COUNT_RST;
      own_up     <= '0;
      row_ok     <= '0;
      visited    <= '0;
      front      <= '0;
      nxt        <= '0;
      stale      <= 1'b1;
      p_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            req_a       <= req.node_a;
            req_b       <= req.node_b;
            req_present <= req.present;
            case (req.func)
              FN_SET_LINK: begin
                if (a_ok) begin
                  own_up[in_idx] <= req.present;
                end
                stale <= 1'b1;
              end
              FN_WRITE_EDGE: begin
                stale <= 1'b1;
                if (a_ok && b_ok) begin
                  state <= S_EDGE_WR;
                end
              end
              FN_CLEAR_ROW: begin
                if (a_ok) begin
                  row_ok[in_idx] <= 1'b0;
                end
                stale <= 1'b1;
              end
              FN_QUERY: begin
                state <= stale ? S_RC_INIT : S_Q_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_EDGE_WR: begin
          row_ok[IW'(req_a)] <= 1'b1;
          state              <= S_IDLE;
        end

        S_RC_INIT: begin
          nxt <= '0;
          u   <= '0;
          if (!self_in) begin
            visited <= '0;
            front   <= '0;
            stale   <= 1'b0;
            state   <= S_Q_RD;
          end else begin
            visited <= MAX_NODES'(1) << self_idx;
            front   <= MAX_NODES'(1) << self_idx;
            state   <= S_RC_SCANU;
          end
        end

        S_RC_SCANU: begin
          if (u == n_eff) begin
            // end of a level: advance to the next frontier or finish
            if (nxt == '0) begin
              stale <= 1'b0;
              state <= S_Q_RD;
            end else begin
              front <= nxt;
              nxt   <= '0;
              u     <= '0;
            end
          end else if (front[u_idx]) begin
            state <= S_RC_LOADU;
          end else begin
            u <= u + CW'(1);
          end
        end

        S_RC_LOADU: begin
          row_u   <= row_ok[u_idx] ? e_rdata : '0;
          hop_u   <= h_rdata;
          v       <= '0;
          p_valid <= 1'b0;
          state   <= S_RC_SCANV;
        end

        S_RC_SCANV: begin
          if (v != n_eff) begin
            p_valid <= 1'b1;
            p_v     <= v[IW-1:0];
            v       <= v + CW'(1);
          end else begin
            p_valid <= 1'b0;
          end
          if (p_valid && take) begin
            visited[p_v] <= 1'b1;
            nxt[p_v]     <= 1'b1;
          end
          if ((v == n_eff) && !p_valid) begin
            u     <= u + CW'(1);
            state <= S_RC_SCANU;
          end
        end

        S_Q_RD: begin
          state <= S_Q_ANS;
        end

        S_Q_ANS: begin
          // hold until the response register is free
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_hop   <= q_hop;
            out_ok    <= q_ok;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SELF_ID: begin
            self_id <= NODE_W'(cfg.data);
            stale   <= 1'b1;
          end
          REG_NODE_COUNT: begin
            node_count <= COUNT_W'(cfg.data);
            stale      <= 1'b1;
          end
          default: begin
            stale <= stale;
          end
        endcase
      end
    end
  end

endmodule

@@ test/shortest_path_next_hop_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_next_hop_top_tb
// Self-checking bench for the next-hop router. A directed table covers the
// topology corner cases, then random phases under different self/count
// settings build small networks and query them. Route answers are compared
// with fixed table values or a unit-weight shortest-path bench predictor.
// ----------------------------------------------------------------------------
module shortest_path_next_hop_top_tb;
  import spnh_pkg::*;

  localparam int MAX_NODES  = DEF_MAX_NODES;
  localparam int DIST_INF   = 32'h3f3f3f3f;
  localparam int IDLE_PCT   = 23;
  localparam int SETTLE     = 8;
  localparam int MAX_SHOWN  = 10;
  localparam int NUM_STEPS  = 27;
  localparam int NUM_PHASES = 9;
  localparam int CALM_PHASE = 7;
  localparam cfg_idx_t REG_SPARE_2 = CFG_IDX_W'(2);
  localparam cfg_idx_t REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    node_t hop;
    logic  route;
  } route_t;

  typedef struct packed {
    func_t func;
    node_t a;
    node_t b;
    logic  present;
    logic  fixed;
    node_t hop;
    logic  route;
  } step_t;

  logic clk;
  logic rst;
  bit   calm;
  int   failures;
  int   queries_sent;
  int   updates_sent;
  int   routed_answers;
  int   settings_used;

  // predictor state
  logic [MAX_NODES-1:0] link_up;
  logic [MAX_NODES-1:0] edge_rows [MAX_NODES];
  logic [MAX_NODES-1:0] hop_ok;
  node_t                hop_via [MAX_NODES];
  bit                   stale;
  node_t                cur_self;
  count_t               cur_count;

  route_t pending_routes [$];

  step_t     directed_steps [NUM_STEPS];
  cfg_data_t phase_self  [NUM_PHASES];
  cfg_data_t phase_count [NUM_PHASES];
  int        phase_items [NUM_PHASES];

  spnh_req_if req_ch ();
  spnh_rsp_if rsp_ch ();
  spnh_cfg_if cfg_ch ();

  shortest_path_next_hop_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int live_nodes();
    return (cur_count > MAX_NODES) ? MAX_NODES : int'(cur_count);
  endfunction

  function automatic bit link_usable(int a, int b);
    if (a == b) return 1'b0;
    if (a == int'(cur_self)) return link_up[b];
    if (b == int'(cur_self)) return link_up[a];
    return edge_rows[a][b] | edge_rows[b][a];
  endfunction

  function automatic void rebuild_routes();
    int n;
    int cost [MAX_NODES];
    bit settled [MAX_NODES];
    int best;
    int u;
    bit found;
    n = live_nodes();
    hop_ok = '0;
    for (int i = 0; i < MAX_NODES; i++) hop_via[i] = '0;
    stale = 1'b0;
    if (int'(cur_self) >= n) return;
    for (int i = 0; i < n; i++) begin
      cost[i] = DIST_INF;
      settled[i] = 1'b0;
    end
    cost[cur_self] = 0;
    for (int it = 0; it < n; it++) begin
      found = 1'b0;
      best = DIST_INF;
      u = 0;
      // lowest index wins among equal distances
      for (int i = 0; i < n; i++) begin
        if (!settled[i] && cost[i] < best) begin
          best = cost[i];
          u = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      settled[u] = 1'b1;
      for (int v = 0; v < n; v++) begin
        if (link_usable(u, v) && cost[u] + 1 < cost[v]) begin
          cost[v] = cost[u] + 1;
          if (u == int'(cur_self)) begin
            hop_ok[v] = 1'b1;
            hop_via[v] = node_t'(v);
          end else begin
            hop_ok[v] = hop_ok[u];
            hop_via[v] = hop_via[u];
          end
        end
      end
    end
  endfunction

  function automatic bit route_request(input func_t f, input node_t a, input node_t b,
                                       input logic p, output route_t r);
    r = '0;
    case (f)
      FN_SET_LINK: begin
        link_up[a] = p;
        stale = 1'b1;
      end
      FN_WRITE_EDGE: begin
        edge_rows[a][b] = p;
        stale = 1'b1;
      end
      FN_CLEAR_ROW: begin
        edge_rows[a] = '0;
        stale = 1'b1;
      end
      default: begin
        if (stale) rebuild_routes();
        if (int'(a) < live_nodes() && hop_ok[a] && link_up[hop_via[a]]) begin
          r.hop = hop_via[a];
          r.route = 1'b1;
        end
      end
    endcase
    return f == FN_QUERY;
  endfunction

  function automatic void apply_register(input cfg_idx_t idx, input cfg_data_t value);
    if (idx == REG_SELF_ID) begin
      cur_self = value[NODE_W-1:0];
      stale = 1'b1;
    end else if (idx == REG_NODE_COUNT) begin
      cur_count = value;
      stale = 1'b1;
    end
  endfunction

  function automatic node_t pick_node(int n);
    if (n > 0 && $urandom_range(99) < 85) return node_t'($urandom_range(n - 1));
    return node_t'($urandom_range(MAX_NODES - 1));
  endfunction

  function automatic void flag_mismatch(input string what, input route_t want,
                                        input route_t got);
    failures++;
    if (failures <= MAX_SHOWN)
      $display("route mismatch (%s): expected hop %0d route %0b, got hop %0d route %0b",
               what, want.hop, want.route, got.hop, got.route);
  endfunction

  task automatic send_request(input func_t f, input node_t a, input node_t b,
                              input logic p, input bit fixed, input route_t typed);
    route_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= f;
    req_ch.node_a  <= a;
    req_ch.node_b  <= b;
    req_ch.present <= p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (route_request(f, a, b, p, r)) begin
      pending_routes.push_back(fixed ? typed : r);
      queries_sent++;
    end else begin
      updates_sent++;
    end
  endtask

  task automatic random_request();
    int     pick;
    func_t  f;
    node_t  a;
    node_t  b;
    logic   p;
    pick = $urandom_range(99);
    a = pick_node(live_nodes());
    b = pick_node(live_nodes());
    p = ($urandom_range(99) < 70);
    if (pick < 18)      f = FN_SET_LINK;
    else if (pick < 52) f = FN_WRITE_EDGE;
    else if (pick < 56) f = FN_CLEAR_ROW;
    else                f = FN_QUERY;
    send_request(f, a, b, p, 1'b0, '0);
  endtask

  // drop valid and wait for every outstanding answer
  task automatic hold_requests();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_routes.size() != 0);
  endtask

  task automatic write_register(input cfg_idx_t idx, input cfg_data_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_register(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : route_check
    route_t want;
    route_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.hop = rsp_ch.next_hop;
      got.route = rsp_ch.has_route;
      if (got.route) routed_answers++;
      if (pending_routes.size() == 0) begin
        flag_mismatch("no query pending", '0, got);
      end else begin
        want = pending_routes.pop_front();
        if (got.hop !== want.hop || got.route !== want.route)
          flag_mismatch("field", want, got);
      end
    end
    rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    // self 0, count 64 out of reset
    directed_steps = '{
      '{FN_QUERY,      6'd5,  6'd0,  1'b0, 1'b1, 6'd0,  1'b0},
      '{FN_QUERY,      6'd0,  6'd63, 1'b1, 1'b1, 6'd0,  1'b0},
      '{FN_SET_LINK,   6'd1,  6'd0,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd1,  6'd0,  1'b0, 1'b1, 6'd1,  1'b1},
      '{FN_WRITE_EDGE, 6'd1,  6'd2,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd2,  6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
      '{FN_WRITE_EDGE, 6'd3,  6'd2,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd3,  6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
      '{FN_SET_LINK,   6'd4,  6'd0,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_SET_LINK,   6'd6,  6'd0,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_WRITE_EDGE, 6'd6,  6'd7,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_WRITE_EDGE, 6'd7,  6'd4,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd7,  6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
      // reported edge touching self does not count without the own link
      '{FN_WRITE_EDGE, 6'd0,  6'd5,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_WRITE_EDGE, 6'd5,  6'd0,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd5,  6'd0,  1'b0, 1'b1, 6'd0,  1'b0},
      '{FN_WRITE_EDGE, 6'd9,  6'd9,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd9,  6'd0,  1'b0, 1'b1, 6'd0,  1'b0},
      '{FN_SET_LINK,   6'd63, 6'd0,  1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd63, 6'd0,  1'b0, 1'b1, 6'd63, 1'b1},
      '{FN_WRITE_EDGE, 6'd63, 6'd62, 1'b1, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd62, 6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
      '{FN_CLEAR_ROW,  6'd1,  6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd2,  6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
      '{FN_SET_LINK,   6'd1,  6'd0,  1'b0, 1'b0, 6'd0,  1'b0},
      '{FN_QUERY,      6'd1,  6'd0,  1'b0, 1'b1, 6'd0,  1'b0},
      '{FN_WRITE_EDGE, 6'd6,  6'd7,  1'b0, 1'b0, 6'd0,  1'b0}
    };
    // self, count, item count per random phase; self 127 wraps to node 63
    phase_self  = '{7'd3, 7'd0, 7'd127, 7'd40, 7'd5, 7'd7, 7'd2, 7'd10, 7'd1};
    phase_count = '{7'd8, 7'd1, 7'd64,  7'd16, 7'd0, 7'd127, 7'd12, 7'd16, 7'd4};
    phase_items = '{150,  30,   50,     30,    20,   40,     200,   200,   180};

    rst            = 1'b1;
    calm           = 1'b0;
    failures       = 0;
    queries_sent   = 0;
    updates_sent   = 0;
    routed_answers = 0;
    settings_used  = 1;
    req_ch.valid   = 1'b0;
    req_ch.func    = FN_SET_LINK;
    req_ch.node_a  = '0;
    req_ch.node_b  = '0;
    req_ch.present = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_SELF_ID;
    cfg_ch.data    = '0;
    rsp_ch.ready   = 1'b0;
    link_up        = '0;
    hop_ok         = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      edge_rows[i] = '0;
      hop_via[i]   = '0;
    end
    stale     = 1'b1;
    cur_self  = '0;
    cur_count = NODE_COUNT_RST;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i])
      send_request(directed_steps[i].func, directed_steps[i].a, directed_steps[i].b,
                   directed_steps[i].present, directed_steps[i].fixed,
                   '{hop: directed_steps[i].hop, route: directed_steps[i].route});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      hold_requests();
      repeat (SETTLE) @(posedge clk);
      // spare indexes must be ignored
      if (ph == 3) write_register(REG_SPARE_2, cfg_data_t'($urandom_range(127)));
      if (ph == 5) write_register(REG_SPARE_3, cfg_data_t'($urandom_range(127)));
      write_register(REG_SELF_ID, phase_self[ph]);
      write_register(REG_NODE_COUNT, phase_count[ph]);
      settings_used++;
      calm = (ph == CALM_PHASE);
      for (int k = 0; k < phase_items[ph]; k++) begin
        if (ph == 0 && k == phase_items[ph] / 2) hold_requests();
        random_request();
      end
    end

    hold_requests();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d topology updates and %0d route queries over %0d settings",
             updates_sent, queries_sent, settings_used);
    $display("%0d answers gave a usable first hop; %0d mismatches",
             routed_answers, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/spnh_pkg.sv
hdl/spnh_if.sv
hdl/spnh_ram.sv
hdl/spnh_relax.sv
hdl/shortest_path_next_hop_top.sv
test/shortest_path_next_hop_top_tb.sv
